### src/bsm_pkg.sv
// Shared types and constants of the byte stack machine.
package bsm_pkg;

    // Default storage sizes
    localparam int CODE_DEPTH_DEF = 1024;
    localparam int DATA_BYTES_DEF = 4096;

    // Action codes carried in the cmd field
    localparam logic [2:0] CMD_LOAD_CODE = 3'd0;
    localparam logic [2:0] CMD_START     = 3'd1;
    localparam logic [2:0] CMD_CLEAR     = 3'd2;
    localparam logic [2:0] CMD_STEP      = 3'd3;
    localparam logic [2:0] CMD_PUSH      = 3'd4;
    localparam logic [2:0] CMD_GET       = 3'd5;

    // Status codes
    localparam logic [2:0] ST_OK      = 3'd0;
    localparam logic [2:0] ST_UNKNOWN = 3'd1;
    localparam logic [2:0] ST_UNDER   = 3'd2;
    localparam logic [2:0] ST_OVER    = 3'd3;
    localparam logic [2:0] ST_RANGE   = 3'd4;

    // Opcodes
    localparam logic [3:0] OP_HALT    = 4'd0;
    localparam logic [3:0] OP_INCSP   = 4'd1;
    localparam logic [3:0] OP_MEMMOVE = 4'd2;
    localparam logic [3:0] OP_ADD     = 4'd3;
    localparam logic [3:0] OP_SUB     = 4'd4;
    localparam logic [3:0] OP_LOAD    = 4'd5;
    localparam logic [3:0] OP_LOADIMM = 4'd6;
    localparam logic [3:0] OP_JMP     = 4'd7;
    localparam logic [3:0] OP_JGE     = 4'd8;
    localparam logic [3:0] OP_JLE     = 4'd9;
    localparam logic [3:0] OP_JGT     = 4'd10;
    localparam logic [3:0] OP_JLT     = 4'd11;
    localparam logic [3:0] OP_JNE     = 4'd12;
    localparam logic [3:0] OP_JEQ     = 4'd13;
    localparam logic [3:0] OP_JZE     = 4'd14;
    localparam logic [3:0] OP_JNZ     = 4'd15;

    // Bytes in one stack integer
    localparam int INT_BYTES = 4;

    typedef struct packed {
        logic [2:0]  cmd;
        logic [9:0]  address;
        logic [31:0] word;
        logic [4:0]  alignment;
        logic [2:0]  size;
    } in_word_t;

    typedef struct packed {
        logic        running;
        logic [9:0]  pointer;
        logic [12:0] stack_level;
        logic [31:0] read_value;
        logic [2:0]  status;
    } out_word_t;

endpackage

### src/byte_stack_machine_step.sv
// Top level of the byte stack machine: sequencer around a code memory and a byte data memory.
//
//  channel | dir | handshake          | payload
//  s_      | in  | s_valid / s_ready  | s_word (cmd, address, word, alignment, size)
//  m_      | out | m_valid / m_ready  | m_word (running, pointer, stack_level, read_value, status)
//
// One word is worked on at a time. Load code goes straight to the final code read and
// hand-off; start and clear pass through commit first. Push and get first work out the
// pad as a bit-serial remainder, then check the bounds and move one byte per cycle.
// Step costs one code-memory read per operand word; add, sub and compares read the
// data memory one byte a cycle; memmove, load and loadimm alternate a read state and
// a write state for each byte moved.
// Reset clears pointer, stack level and read cursor; the memories are not cleared.
// A waiting result does not block acceptance of the next word; the sequencer only
// stalls at its final state while the output register is still full.
module byte_stack_machine_step #(
    parameter int CODE_DEPTH = bsm_pkg::CODE_DEPTH_DEF,
    parameter int DATA_BYTES = bsm_pkg::DATA_BYTES_DEF
) (
    input  logic              aclk,
    input  logic              aresetn,
    input  logic              s_valid,
    output logic              s_ready,
    input  bsm_pkg::in_word_t s_word,
    output logic              m_valid,
    input  logic              m_ready,
    output bsm_pkg::out_word_t m_word
);

    localparam int CAW = (CODE_DEPTH > 1) ? $clog2(CODE_DEPTH) : 1;
    localparam int DAW = (DATA_BYTES > 1) ? $clog2(DATA_BYTES) : 1;
    localparam int DCW = $clog2(DATA_BYTES + 1);
    localparam int NCW = $clog2(DCW);

    typedef enum logic [21:0] {
        S_IDLE     = 22'h000001,
        S_DIV      = 22'h000002,
        S_PUSH_CHK = 22'h000004,
        S_GET_CHK  = 22'h000008,
        S_GET_DONE = 22'h000010,
        S_OP       = 22'h000020,
        S_OPA      = 22'h000040,
        S_OPB      = 22'h000080,
        S_OPC      = 22'h000100,
        S_AS_T     = 22'h000200,
        S_AS_U     = 22'h000400,
        S_JB       = 22'h000800,
        S_JCMP     = 22'h001000,
        S_IMM      = 22'h002000,
        S_IMM_WR   = 22'h004000,
        S_MV_RD    = 22'h008000,
        S_MV_WR    = 22'h010000,
        S_RDB      = 22'h020000,
        S_WRB      = 22'h040000,
        S_COMMIT   = 22'h080000,
        S_FIN_RD   = 22'h100000,
        S_FIN      = 22'h200000
    } state_t;

    // Memories
    logic [31:0] code_mem [CODE_DEPTH];
    logic [7:0]  data_mem [DATA_BYTES];
    logic [31:0] code_q_reg;
    logic [7:0]  data_q_reg;

    logic           code_we, code_re, data_we, data_re;
    logic [CAW-1:0] code_waddr, code_raddr;
    logic [31:0]    code_wdata;
    logic [DAW-1:0] data_waddr, data_raddr;
    logic [7:0]     data_wdata;

    // Sequencer registers
    state_t            state_reg, state_next, ret_reg, ret_next;
    bsm_pkg::in_word_t in_reg, in_next;
    logic [CAW-1:0]    ip_reg, ip_next, ip_new_reg, ip_new_next;
    logic [DCW-1:0]    sc_reg, sc_next, sc_new_reg, sc_new_next;
    logic [DCW-1:0]    rc_reg, rc_next, rc_new_reg, rc_new_next;
    logic [2:0]        status_reg, status_next;
    logic [31:0]       value_reg, value_next;
    logic [3:0]        op_reg, op_next;
    logic [31:0]       opa_reg, opa_next, opb_reg, opb_next;
    logic [DCW-1:0]    base_reg, base_next, len_reg, len_next, k_reg, k_next;
    logic [DCW-1:0]    src_reg, src_next;
    logic              down_reg, down_next;
    logic [31:0]       acc_reg, acc_next, wword_reg, wword_next, tmp_reg, tmp_next;
    logic [4:0]        align_reg, align_next, rem_reg, rem_next;
    logic [DCW-1:0]    divq_reg, divq_next;
    logic [NCW-1:0]    dcnt_reg, dcnt_next;
    logic              m_valid_reg, m_valid_next;
    bsm_pkg::out_word_t out_reg, out_next;

    // Wide helpers for range checks
    logic [33:0] ip_w, sc_w, rc_w, cd_w, db_w, opa_w, tot_w, hi_w;
    logic signed [33:0] target_w;
    logic [4:0]  pad;
    logic [2:0]  size_eff;
    logic [5:0]  div_sh;
    logic [DCW-1:0] need, mv_off;
    logic [1:0]  rd_byte;
    logic        jump;
    logic [31:0] code_q;

    assign s_ready = (state_reg == S_IDLE);
    assign m_valid = m_valid_reg;
    assign m_word  = out_reg;
    assign code_q  = code_q_reg;

    // Code memory
    always_ff @(posedge aclk) begin
        if (code_we) begin
            code_mem[code_waddr] <= code_wdata;
        end
        if (code_re) begin
            code_q_reg <= code_mem[code_raddr];
        end
    end

    // Data memory
    always_ff @(posedge aclk) begin
        if (data_we) begin
            data_mem[data_waddr] <= data_wdata;
        end
        if (data_re) begin
            data_q_reg <= data_mem[data_raddr];
        end
    end

    // Shared helper values
    always_comb begin
        ip_w     = 34'(ip_reg);
        sc_w     = 34'(sc_reg);
        rc_w     = 34'(rc_reg);
        cd_w     = 34'(CODE_DEPTH);
        db_w     = 34'(DATA_BYTES);
        opa_w    = 34'(opa_reg);
        hi_w     = (opa_reg > opb_reg) ? opa_w : 34'(opb_reg);
        pad      = (rem_reg == 5'd0) ? 5'd0 : align_reg - rem_reg;
        size_eff = (in_reg.size > 3'd4) ? 3'd4 : in_reg.size;
        div_sh   = {rem_reg, divq_reg[DCW-1]};
        mv_off   = down_reg ? (len_reg - k_reg - DCW'(1)) : k_reg;
        rd_byte  = 2'(k_reg - DCW'(1));
        target_w = $signed(ip_w) + 34'sd2 + $signed({{2{opa_reg[31]}}, opa_reg});
        case (op_reg)
            bsm_pkg::OP_JMP: need = DCW'(0);
            bsm_pkg::OP_JZE,
            bsm_pkg::OP_JNZ: need = DCW'(bsm_pkg::INT_BYTES);
            default:         need = DCW'(2 * bsm_pkg::INT_BYTES);
        endcase
        case (op_reg)
            bsm_pkg::OP_JGE: jump = $signed(acc_reg) >= $signed(tmp_reg);
            bsm_pkg::OP_JLE: jump = $signed(acc_reg) <= $signed(tmp_reg);
            bsm_pkg::OP_JGT: jump = $signed(acc_reg) >  $signed(tmp_reg);
            bsm_pkg::OP_JLT: jump = $signed(acc_reg) <  $signed(tmp_reg);
            bsm_pkg::OP_JNE: jump = acc_reg != tmp_reg;
            bsm_pkg::OP_JEQ: jump = acc_reg == tmp_reg;
            bsm_pkg::OP_JZE: jump = acc_reg == 32'd0;
            bsm_pkg::OP_JNZ: jump = acc_reg != 32'd0;
            default:         jump = 1'b1;
        endcase
    end

    // Sequencer
    always_comb begin
        state_next   = state_reg;
        ret_next     = ret_reg;
        in_next      = in_reg;
        ip_next      = ip_reg;
        sc_next      = sc_reg;
        rc_next      = rc_reg;
        ip_new_next  = ip_new_reg;
        sc_new_next  = sc_new_reg;
        rc_new_next  = rc_new_reg;
        status_next  = status_reg;
        value_next   = value_reg;
        op_next      = op_reg;
        opa_next     = opa_reg;
        opb_next     = opb_reg;
        base_next    = base_reg;
        len_next     = len_reg;
        k_next       = k_reg;
        src_next     = src_reg;
        down_next    = down_reg;
        acc_next     = acc_reg;
        wword_next   = wword_reg;
        tmp_next     = tmp_reg;
        align_next   = align_reg;
        rem_next     = rem_reg;
        divq_next    = divq_reg;
        dcnt_next    = dcnt_reg;
        out_next     = out_reg;
        m_valid_next = m_valid_reg && !m_ready;
        tot_w        = '0;
        code_we      = 1'b0;
        code_re      = 1'b0;
        code_waddr   = '0;
        code_raddr   = ip_reg;
        code_wdata   = s_word.word;
        data_we      = 1'b0;
        data_re      = 1'b0;
        data_waddr   = '0;
        data_raddr   = '0;
        data_wdata   = '0;

        case (state_reg)
            S_IDLE: begin
                if (s_valid) begin
                    in_next     = s_word;
                    ip_new_next = ip_reg;
                    sc_new_next = sc_reg;
                    rc_new_next = rc_reg;
                    status_next = bsm_pkg::ST_OK;
                    value_next  = '0;
                    align_next  = (s_word.alignment == 5'd0) ? 5'd1 : s_word.alignment;
                    rem_next    = '0;
                    dcnt_next   = '0;
                    case (s_word.cmd)
                        bsm_pkg::CMD_LOAD_CODE: begin
                            if (34'(s_word.address) < cd_w) begin
                                code_we    = 1'b1;
                                code_waddr = CAW'(s_word.address);
                            end else begin
                                status_next = bsm_pkg::ST_RANGE;
                            end
                            state_next = S_FIN_RD;
                        end
                        bsm_pkg::CMD_START: begin
                            if (34'(s_word.address) < cd_w) begin
                                ip_new_next = CAW'(s_word.address);
                                rc_new_next = '0;
                                state_next  = S_COMMIT;
                            end else begin
                                status_next = bsm_pkg::ST_RANGE;
                                state_next  = S_FIN_RD;
                            end
                        end
                        bsm_pkg::CMD_CLEAR: begin
                            sc_new_next = '0;
                            state_next  = S_COMMIT;
                        end
                        bsm_pkg::CMD_STEP: begin
                            code_re    = 1'b1;
                            code_raddr = ip_reg;
                            state_next = S_OP;
                        end
                        bsm_pkg::CMD_PUSH: begin
                            divq_next  = sc_reg;
                            ret_next   = S_PUSH_CHK;
                            state_next = S_DIV;
                        end
                        bsm_pkg::CMD_GET: begin
                            divq_next  = rc_reg;
                            ret_next   = S_GET_CHK;
                            state_next = S_DIV;
                        end
                        default: state_next = S_FIN_RD;
                    endcase
                end
            end

            // One remainder bit per cycle: position mod alignment
            S_DIV: begin
                if (div_sh >= {1'b0, align_reg}) begin
                    rem_next = 5'(div_sh - {1'b0, align_reg});
                end else begin
                    rem_next = div_sh[4:0];
                end
                divq_next = divq_reg << 1;
                dcnt_next = dcnt_reg + NCW'(1);
                if (dcnt_reg == NCW'(DCW - 1)) begin
                    state_next = ret_reg;
                end
            end

            S_PUSH_CHK: begin
                tot_w = sc_w + 34'(pad) + 34'(size_eff);
                if (tot_w > db_w) begin
                    status_next = bsm_pkg::ST_OVER;
                    state_next  = S_FIN_RD;
                end else begin
                    base_next   = sc_reg + DCW'(pad);
                    len_next    = DCW'(size_eff);
                    k_next      = '0;
                    wword_next  = in_reg.word;
                    sc_new_next = DCW'(tot_w);
                    ret_next    = S_COMMIT;
                    state_next  = S_WRB;
                end
            end

            S_GET_CHK: begin
                tot_w = rc_w + 34'(pad) + 34'(size_eff);
                if (tot_w > sc_w) begin
                    status_next = bsm_pkg::ST_UNDER;
                    state_next  = S_FIN_RD;
                end else begin
                    base_next   = rc_reg + DCW'(pad);
                    len_next    = DCW'(size_eff);
                    k_next      = '0;
                    acc_next    = '0;
                    rc_new_next = DCW'(tot_w);
                    ret_next    = S_GET_DONE;
                    state_next  = S_RDB;
                end
            end

            S_GET_DONE: begin
                value_next = acc_reg;
                state_next = S_COMMIT;
            end

            // Opcode word arrives
            S_OP: begin
                op_next = code_q[3:0];
                if (code_q == 32'd0) begin
                    state_next = S_FIN_RD;
                end else if (code_q > 32'd15) begin
                    status_next = bsm_pkg::ST_UNKNOWN;
                    state_next  = S_FIN_RD;
                end else if (code_q[3:0] == bsm_pkg::OP_ADD ||
                             code_q[3:0] == bsm_pkg::OP_SUB) begin
                    if (sc_reg < DCW'(2 * bsm_pkg::INT_BYTES)) begin
                        status_next = bsm_pkg::ST_UNDER;
                        state_next  = S_FIN_RD;
                    end else if (ip_w + 34'd1 >= cd_w) begin
                        status_next = bsm_pkg::ST_RANGE;
                        state_next  = S_FIN_RD;
                    end else begin
                        base_next  = sc_reg - DCW'(bsm_pkg::INT_BYTES);
                        len_next   = DCW'(bsm_pkg::INT_BYTES);
                        k_next     = '0;
                        acc_next   = '0;
                        ret_next   = S_AS_T;
                        state_next = S_RDB;
                    end
                end else if (ip_w + 34'd1 >= cd_w) begin
                    status_next = bsm_pkg::ST_RANGE;
                    state_next  = S_FIN_RD;
                end else begin
                    code_re    = 1'b1;
                    code_raddr = CAW'(ip_w + 34'd1);
                    state_next = S_OPA;
                end
            end

            // First operand word arrives
            S_OPA: begin
                opa_next   = code_q;
                state_next = S_FIN_RD;
                case (op_reg)
                    bsm_pkg::OP_INCSP: begin
                        if (sc_w + 34'(code_q) > db_w) begin
                            status_next = bsm_pkg::ST_OVER;
                        end else if (ip_w + 34'd2 >= cd_w) begin
                            status_next = bsm_pkg::ST_RANGE;
                        end else begin
                            sc_new_next = DCW'(sc_w + 34'(code_q));
                            ip_new_next = CAW'(ip_w + 34'd2);
                            state_next  = S_COMMIT;
                        end
                    end
                    bsm_pkg::OP_MEMMOVE,
                    bsm_pkg::OP_LOAD: begin
                        if (ip_w + ((op_reg == bsm_pkg::OP_MEMMOVE) ? 34'd3 : 34'd2) >= cd_w)
                        begin
                            status_next = bsm_pkg::ST_RANGE;
                        end else begin
                            code_re    = 1'b1;
                            code_raddr = CAW'(ip_w + 34'd2);
                            state_next = S_OPB;
                        end
                    end
                    bsm_pkg::OP_LOADIMM: begin
                        // opa_reg is not loaded yet; use the fresh word
                        tot_w = ip_w + 34'd2 + ((34'(code_q) + 34'd3) >> 2);
                        if (tot_w > cd_w) begin
                            status_next = bsm_pkg::ST_RANGE;
                        end else if (sc_w + 34'(code_q) > db_w) begin
                            status_next = bsm_pkg::ST_OVER;
                        end else if (tot_w >= cd_w) begin
                            status_next = bsm_pkg::ST_RANGE;
                        end else begin
                            sc_new_next = DCW'(sc_w + 34'(code_q));
                            ip_new_next = CAW'(tot_w);
                            base_next   = sc_reg;
                            len_next    = DCW'(code_q);
                            k_next      = '0;
                            state_next  = S_IMM;
                        end
                    end
                    default: begin
                        // compare and jump forms
                        if (sc_reg < need) begin
                            status_next = bsm_pkg::ST_UNDER;
                        end else if (need == DCW'(0)) begin
                            state_next = S_JCMP;
                        end else begin
                            base_next  = sc_reg - DCW'(bsm_pkg::INT_BYTES);
                            len_next   = DCW'(bsm_pkg::INT_BYTES);
                            k_next     = '0;
                            acc_next   = '0;
                            ret_next   = (need == DCW'(bsm_pkg::INT_BYTES)) ? S_JCMP : S_JB;
                            state_next = S_RDB;
                        end
                    end
                endcase
            end

            S_OPB: begin
                opb_next = code_q;
                if (op_reg == bsm_pkg::OP_MEMMOVE) begin
                    code_re    = 1'b1;
                    code_raddr = CAW'(ip_w + 34'd3);
                    state_next = S_OPC;
                end else begin
                    // load: offset in opa, count in this word
                    state_next = S_FIN_RD;
                    if (sc_w + 34'(code_q) > db_w) begin
                        status_next = bsm_pkg::ST_OVER;
                    end else if (opa_w + 34'(code_q) > db_w) begin
                        status_next = bsm_pkg::ST_OVER;
                    end else if (ip_w + 34'd3 >= cd_w) begin
                        status_next = bsm_pkg::ST_RANGE;
                    end else begin
                        base_next   = sc_reg;
                        src_next    = DCW'(opa_reg);
                        len_next    = DCW'(code_q);
                        down_next   = sc_w > opa_w;
                        k_next      = '0;
                        sc_new_next = DCW'(sc_w + 34'(code_q));
                        ip_new_next = CAW'(ip_w + 34'd3);
                        state_next  = S_MV_RD;
                    end
                end
            end

            // memmove count arrives: dst in opa, src in opb
            S_OPC: begin
                state_next = S_FIN_RD;
                if (hi_w + 34'(code_q) > db_w) begin
                    status_next = bsm_pkg::ST_OVER;
                end else if (ip_w + 34'd4 >= cd_w) begin
                    status_next = bsm_pkg::ST_RANGE;
                end else begin
                    base_next   = DCW'(opa_reg);
                    src_next    = DCW'(opb_reg);
                    len_next    = DCW'(code_q);
                    down_next   = opa_reg > opb_reg;
                    k_next      = '0;
                    ip_new_next = CAW'(ip_w + 34'd4);
                    state_next  = S_MV_RD;
                end
            end

            S_AS_T: begin
                tmp_next   = acc_reg;
                base_next  = sc_reg - DCW'(2 * bsm_pkg::INT_BYTES);
                k_next     = '0;
                acc_next   = '0;
                ret_next   = S_AS_U;
                state_next = S_RDB;
            end

            S_AS_U: begin
                wword_next  = (op_reg == bsm_pkg::OP_ADD) ? tmp_reg + acc_reg
                                                          : tmp_reg - acc_reg;
                base_next   = sc_reg - DCW'(2 * bsm_pkg::INT_BYTES);
                k_next      = '0;
                sc_new_next = sc_reg - DCW'(bsm_pkg::INT_BYTES);
                ip_new_next = CAW'(ip_w + 34'd1);
                ret_next    = S_COMMIT;
                state_next  = S_WRB;
            end

            S_JB: begin
                tmp_next   = acc_reg;
                base_next  = sc_reg - DCW'(2 * bsm_pkg::INT_BYTES);
                k_next     = '0;
                acc_next   = '0;
                ret_next   = S_JCMP;
                state_next = S_RDB;
            end

            S_JCMP: begin
                tot_w = jump ? 34'(target_w) : ip_w + 34'd2;
                if (tot_w[33] || tot_w >= cd_w) begin
                    status_next = bsm_pkg::ST_RANGE;
                    state_next  = S_FIN_RD;
                end else begin
                    sc_new_next = sc_reg - need;
                    ip_new_next = CAW'(tot_w);
                    state_next  = S_COMMIT;
                end
            end

            // Inline immediate bytes, one code read per byte
            S_IMM: begin
                if (k_reg == len_reg) begin
                    state_next = S_COMMIT;
                end else begin
                    code_re    = 1'b1;
                    code_raddr = CAW'(ip_w + 34'd2 + 34'(k_reg >> 2));
                    state_next = S_IMM_WR;
                end
            end

            S_IMM_WR: begin
                data_we    = 1'b1;
                data_waddr = DAW'(base_reg + k_reg);
                data_wdata = code_q[{k_reg[1:0], 3'b000} +: 8];
                k_next     = k_reg + DCW'(1);
                state_next = S_IMM;
            end

            // Byte copy; runs top down when the target lies above the source
            S_MV_RD: begin
                if (k_reg == len_reg) begin
                    state_next = S_COMMIT;
                end else begin
                    data_re    = 1'b1;
                    data_raddr = DAW'(src_reg + mv_off);
                    state_next = S_MV_WR;
                end
            end

            S_MV_WR: begin
                data_we    = 1'b1;
                data_waddr = DAW'(base_reg + mv_off);
                data_wdata = data_q_reg;
                k_next     = k_reg + DCW'(1);
                state_next = S_MV_RD;
            end

            // Read len bytes from base, pipelined one byte a cycle
            S_RDB: begin
                if (k_reg != len_reg) begin
                    data_re    = 1'b1;
                    data_raddr = DAW'(base_reg + k_reg);
                end
                if (k_reg != DCW'(0)) begin
                    acc_next[{rd_byte, 3'b000} +: 8] = data_q_reg;
                end
                if (k_reg == len_reg) begin
                    state_next = ret_reg;
                end else begin
                    k_next = k_reg + DCW'(1);
                end
            end

            // Write len bytes of wword at base
            S_WRB: begin
                if (k_reg == len_reg) begin
                    state_next = ret_reg;
                end else begin
                    data_we    = 1'b1;
                    data_waddr = DAW'(base_reg + k_reg);
                    data_wdata = wword_reg[{k_reg[1:0], 3'b000} +: 8];
                    k_next     = k_reg + DCW'(1);
                end
            end

            S_COMMIT: begin
                ip_next    = ip_new_reg;
                sc_next    = sc_new_reg;
                rc_next    = rc_new_reg;
                state_next = S_FIN_RD;
            end

            S_FIN_RD: begin
                code_re    = 1'b1;
                code_raddr = ip_reg;
                state_next = S_FIN;
            end

            // Hand the result over once the output register is free
            S_FIN: begin
                if (!m_valid_reg || m_ready) begin
                    out_next.running     = code_q != 32'd0;
                    out_next.pointer     = 10'(ip_reg);
                    out_next.stack_level = 13'(sc_reg);
                    out_next.read_value  = value_reg;
                    out_next.status      = status_reg;
                    m_valid_next         = 1'b1;
                    state_next           = S_IDLE;
                end
            end

            default: state_next = S_IDLE;
        endcase
    end

    // Control registers
    always_ff @(posedge aclk) begin
        if (!aresetn) begin
            state_reg   <= S_IDLE;
            ip_reg      <= '0;
            sc_reg      <= '0;
            rc_reg      <= '0;
            m_valid_reg <= 1'b0;
        end else begin
            state_reg   <= state_next;
            ip_reg      <= ip_next;
            sc_reg      <= sc_next;
            rc_reg      <= rc_next;
            m_valid_reg <= m_valid_next;
        end
    end

    // Payload registers
    always_ff @(posedge aclk) begin
        ret_reg    <= ret_next;
        in_reg     <= in_next;
        ip_new_reg <= ip_new_next;
        sc_new_reg <= sc_new_next;
        rc_new_reg <= rc_new_next;
        status_reg <= status_next;
        value_reg  <= value_next;
        op_reg     <= op_next;
        opa_reg    <= opa_next;
        opb_reg    <= opb_next;
        base_reg   <= base_next;
        len_reg    <= len_next;
        k_reg      <= k_next;
        src_reg    <= src_next;
        down_reg   <= down_next;
        acc_reg    <= acc_next;
        wword_reg  <= wword_next;
        tmp_reg    <= tmp_next;
        align_reg  <= align_next;
        rem_reg    <= rem_next;
        divq_reg   <= divq_next;
        dcnt_reg   <= dcnt_next;
        out_reg    <= out_next;
    end

    // Stack level never exceeds the data memory
    a_sc_bound: assert property (@(posedge aclk) disable iff (!aresetn)
        34'(sc_reg) <= 34'(DATA_BYTES))
        else $error("stack level beyond data memory");

    // Instruction pointer stays inside the code memory
    a_ip_bound: assert property (@(posedge aclk) disable iff (!aresetn)
        34'(ip_reg) < 34'(CODE_DEPTH))
        else $error("instruction pointer out of code memory");

    // Only one word in flight: no accept right after an accept
    a_one_word: assert property (@(posedge aclk) disable iff (!aresetn)
        (s_valid && s_ready) |=> !s_ready)
        else $error("second word accepted while busy");

    // Code memory is written only when a load code word is taken
    a_code_we: assert property (@(posedge aclk) disable iff (!aresetn)
        code_we |-> (s_valid && s_ready && s_word.cmd == bsm_pkg::CMD_LOAD_CODE))
        else $error("unexpected code memory write");

    // Architectural state changes only in the commit step
    a_commit: assert property (@(posedge aclk) disable iff (!aresetn)
        (state_reg != S_COMMIT) |=> ($stable(ip_reg) && $stable(rc_reg)))
        else $error("pointer or cursor changed outside commit");

endmodule
